[sv/jves_pkg.sv]
package jves_pkg;

    // end status codes
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_BUFFER_END = 2'd1;
    localparam logic [1:0] ST_OVERFLOW   = 2'd2;

    // byte class as produced by the front end
    typedef struct packed {
        logic last;
        logic is_zero;
        logic is_blank;
        logic is_quote;
        logic is_bslash;
        logic is_lbrack;
        logic is_rbrack;
        logic is_lbrace;
        logic is_rbrace;
        logic is_colon;
        logic is_comma;
        logic tok_start;
        logic tok_byte;
    } item_t;

    typedef enum logic [4:0] {
        MODE_EXPECT = 5'b00001,
        MODE_AFTER  = 5'b00010,
        MODE_STRING = 5'b00100,
        MODE_ESCAPE = 5'b01000,
        MODE_TOKEN  = 5'b10000
    } scan_mode_t;

    typedef enum logic [1:0] {
        LVL_ARRAY = 2'd0,
        LVL_KEY   = 2'd1,
        LVL_VALUE = 2'd2
    } level_t;

    typedef enum logic [3:0] {
        BK_IDLE   = 4'b0001,
        BK_FETCH  = 4'b0010,
        BK_UNWIND = 4'b0100,
        BK_REFILL = 4'b1000
    } bk_state_t;

    typedef struct packed {
        logic busy;
        logic emit;
    } bk_status_t;

endpackage

[sv/jves_ram.sv]
module jves_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/jves_front.sv]
module jves_front import jves_pkg::*; (
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       q_ready,
    output logic       q_push,
    output item_t      q_item
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    logic is_alnum;

    assign is_alnum = (data_byte >= 8'h30 && data_byte <= 8'h39)
                   || (data_byte >= 8'h61 && data_byte <= 8'h7A)
                   || (data_byte >= 8'h41 && data_byte <= 8'h5A);

    always_comb
    begin
        q_item.last      = last_byte;
        q_item.is_zero   = (data_byte == 8'h00);
        q_item.is_blank  = (data_byte == 8'h20) || (data_byte == 8'h09)
                        || (data_byte == 8'h0A) || (data_byte == 8'h0D);
        q_item.is_quote  = (data_byte == CH_QUOTE);
        q_item.is_bslash = (data_byte == CH_BSLASH);
        q_item.is_lbrack = (data_byte == CH_LBRACK);
        q_item.is_rbrack = (data_byte == CH_RBRACK);
        q_item.is_lbrace = (data_byte == CH_LBRACE);
        q_item.is_rbrace = (data_byte == CH_RBRACE);
        q_item.is_colon  = (data_byte == CH_COLON);
        q_item.is_comma  = (data_byte == CH_COMMA);
        q_item.tok_start = is_alnum || (data_byte == CH_DOT) || (data_byte == CH_MINUS);
        q_item.tok_byte  = q_item.tok_start || (data_byte == CH_PLUS);
    end

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

endmodule

[sv/jves_queue.sv]
module jves_queue import jves_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    // two entries
    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/jves_back.sv]
module jves_back import jves_pkg::*; #(
    parameter int MAX_DEPTH   = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LENGTH_BITS-1:0] out_len,
    output logic [1:0]             out_status,
    output bk_status_t             status
);

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    bk_state_t              state_reg, state_next;
    scan_mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    level_t                 top_reg, top_next;
    logic [LENGTH_BITS-1:0] bc_reg, bc_next;
    logic                   given_reg, given_next;
    item_t                  cur_reg, cur_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LENGTH_BITS-1:0] out_len_reg, out_len_next;
    logic [1:0]             out_status_reg, out_status_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [1:0]             ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [1:0]             ram_rdata;

    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       cnt_m2;
    logic [LENGTH_BITS-1:0] bc_inc;
    logic                   slot_free;
    item_t                  it;
    logic                   scan_done;
    logic                   sep;
    logic                   res;
    logic [LENGTH_BITS-1:0] res_len;
    logic [1:0]             res_st;
    logic                   emit;
    logic                   take_sep;
    logic                   take_close;

    assign cnt_m1    = count_reg - CNT_W'(1);
    assign cnt_m2    = cnt_m1 - CNT_W'(1);
    assign bc_inc    = (bc_reg == {LENGTH_BITS{1'b1}}) ? bc_reg : bc_reg + LENGTH_BITS'(1);
    assign slot_free = !out_valid_reg || out_ready;

    jves_ram #(
        .WIDTH (2),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        bc_next         = bc_reg;
        given_next      = given_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = LVL_ARRAY;
        ram_re          = 1'b0;
        ram_raddr       = cnt_m2[AW-1:0];
        it              = cur_reg;
        scan_done       = 1'b0;
        sep             = 1'b0;
        res             = 1'b0;
        res_len         = '0;
        res_st          = ST_DONE;
        emit            = 1'b0;
        take_sep        = 1'b0;
        take_close      = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop    = 1'b1;
                    it       = q_item;
                    cur_next = q_item;
                    if (given_reg)
                    begin
                        // result already out, drop bytes until buffer end
                        if (q_item.last)
                        begin
                            mode_next  = MODE_EXPECT;
                            count_next = '0;
                            bc_next    = '0;
                            given_next = 1'b0;
                        end
                    end
                    else
                    begin
                        scan_done = 1'b1;
                        if (q_item.is_zero)
                        begin
                            res     = 1'b1;
                            res_len = (count_reg == '0 && mode_reg == MODE_EXPECT) ? '0 : bc_reg;
                        end
                        else
                        begin
                            unique case (mode_reg)
                                MODE_STRING:
                                begin
                                    if (q_item.is_bslash)
                                    begin
                                        mode_next = MODE_ESCAPE;
                                    end
                                    else if (q_item.is_quote)
                                    begin
                                        mode_next = MODE_AFTER;
                                        if (count_reg == '0)
                                        begin
                                            res     = 1'b1;
                                            res_len = bc_inc;
                                        end
                                    end
                                end
                                MODE_ESCAPE:
                                begin
                                    mode_next = MODE_STRING;
                                end
                                MODE_TOKEN:
                                begin
                                    if (!q_item.tok_byte)
                                    begin
                                        if (count_reg == '0)
                                        begin
                                            res     = 1'b1;
                                            res_len = bc_reg;
                                        end
                                        else
                                        begin
                                            mode_next = MODE_AFTER;
                                            sep       = !q_item.is_blank;
                                        end
                                    end
                                end
                                MODE_AFTER:
                                begin
                                    sep = !q_item.is_blank;
                                end
                                default:
                                begin
                                    mode_next = MODE_EXPECT;
                                    if (q_item.is_blank)
                                    begin
                                        mode_next = MODE_EXPECT;
                                    end
                                    else if (q_item.is_quote)
                                    begin
                                        mode_next = MODE_STRING;
                                    end
                                    else if (q_item.is_lbrack || q_item.is_lbrace)
                                    begin
                                        if (count_reg >= CNT_W'(MAX_DEPTH))
                                        begin
                                            res     = 1'b1;
                                            res_len = bc_reg;
                                            res_st  = ST_OVERFLOW;
                                        end
                                        else
                                        begin
                                            ram_we     = 1'b1;
                                            ram_waddr  = count_reg[AW-1:0];
                                            ram_wdata  = q_item.is_lbrack ? LVL_ARRAY : LVL_KEY;
                                            top_next   = q_item.is_lbrack ? LVL_ARRAY : LVL_KEY;
                                            count_next = count_reg + CNT_W'(1);
                                        end
                                    end
                                    else if (q_item.tok_start)
                                    begin
                                        mode_next = MODE_TOKEN;
                                    end
                                    else if (count_reg == '0)
                                    begin
                                        res     = 1'b1;
                                        res_len = '0;
                                    end
                                    else
                                    begin
                                        sep = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            BK_FETCH:
            begin
                top_next   = level_t'(ram_rdata);
                state_next = BK_IDLE;
            end
            BK_REFILL:
            begin
                top_next   = level_t'(ram_rdata);
                state_next = BK_UNWIND;
            end
            BK_UNWIND:
            begin
                sep       = 1'b1;
                scan_done = 1'b1;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // one level of separator / closer matching per pass
        if (sep)
        begin
            state_next = BK_IDLE;
            if (count_reg == '0)
            begin
                res     = 1'b1;
                res_len = bc_reg;
            end
            else
            begin
                take_sep   = (top_reg == LVL_KEY) ? it.is_colon : it.is_comma;
                take_close = (top_reg == LVL_ARRAY) ? it.is_rbrack : it.is_rbrace;
                if (take_sep)
                begin
                    mode_next = MODE_EXPECT;
                    if (top_reg != LVL_ARRAY)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_m1[AW-1:0];
                        ram_wdata = (top_reg == LVL_KEY) ? LVL_VALUE : LVL_KEY;
                        top_next  = (top_reg == LVL_KEY) ? LVL_VALUE : LVL_KEY;
                    end
                end
                else if (take_close)
                begin
                    count_next = cnt_m1;
                    mode_next  = MODE_AFTER;
                    if (cnt_m1 == '0)
                    begin
                        res     = 1'b1;
                        res_len = bc_inc;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = BK_FETCH;
                    end
                end
                else
                begin
                    count_next = cnt_m1;
                    if (cnt_m1 == '0)
                    begin
                        res     = 1'b1;
                        res_len = bc_reg;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = BK_REFILL;
                        scan_done  = 1'b0;
                    end
                end
            end
        end

        // byte fully handled: count it, buffer end, result
        if (scan_done)
        begin
            if (!res)
            begin
                bc_next = bc_inc;
                if (it.last)
                begin
                    res     = 1'b1;
                    res_st  = ST_BUFFER_END;
                    res_len = (count_next == '0 && mode_next == MODE_EXPECT) ? '0 : bc_inc;
                end
            end
            if (res)
            begin
                emit            = 1'b1;
                given_next      = 1'b1;
                out_valid_next  = 1'b1;
                out_len_next    = res_len;
                out_status_next = res_st;
            end
            if (it.last)
            begin
                mode_next  = MODE_EXPECT;
                count_next = '0;
                bc_next    = '0;
                given_next = 1'b0;
                state_next = BK_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            mode_reg      <= MODE_EXPECT;
            count_reg     <= '0;
            bc_reg        <= '0;
            given_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            bc_reg        <= bc_next;
            given_reg     <= given_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        cur_reg        <= cur_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_len     = out_len_reg;
    assign out_status  = out_status_reg;
    assign status.busy = (state_reg != BK_IDLE);
    assign status.emit = emit;

endmodule

[sv/json_value_extent_scanner.sv]
// path: a byte is stored in the queue, and the back end registers the result it decides
// on that byte in the output register that drives value_length
// throughput: 1 byte per cycle when idle with the output free; a closer that leaves inner
// levels open rereads the top level (FETCH); each level popped passes REFILL and UNWIND
// reset: rst_n clears mode, level count, byte count and handshake state at once;
// the level stack ram is not cleared since entries are only read after being written
module json_value_extent_scanner import jves_pkg::*; #(
    parameter int MAX_DEPTH   = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] value_length,
    output logic [1:0]  end_status
);

    // front to queue
    logic       q_push;
    logic       q_ready;
    item_t      q_in_item;

    // queue to back
    logic       q_valid;
    logic       q_pop;
    item_t      q_out_item;

    // back results, at full internal length
    logic [LENGTH_BITS-1:0] len_int;
    logic [31:0]            len_wide;
    bk_status_t             bk_stat;

    // byte classification, input transfer
    jves_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    // short decoupling queue so input keeps flowing during unwinds
    jves_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out_item)
    );

    // scan state machine, level stack and output register
    jves_back #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_out_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_len    (len_int),
        .out_status (end_status),
        .status     (bk_stat)
    );

    // length port carries the low 16 bits of the saturated count
    assign len_wide     = 32'(len_int);
    assign value_length = len_wide[15:0];

    // back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // no new item is taken while unwinding or reloading the top level
    assert property (@(posedge clk) disable iff (!rst_n) bk_stat.busy |-> !q_pop)
        else $error("queue popped while back end busy");

    // a result is only produced when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.emit |-> (!out_valid || out_ready))
        else $error("result overwrote pending transfer");

    // status code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> end_status != 2'd3)
        else $error("bad end status");

endmodule
